### rtl/core/assert_macros.svh
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/core/cmap_pkg.sv
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared types and constants for the colormap stop interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package cmap_pkg;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [0:0] CFG_RANGE_MIN = 1'b0;
	localparam logic [0:0] CFG_RANGE_MAX = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sample_value;
		logic [16:0] stop_position;
		logic [7:0]  stop_red;
		logic [7:0]  stop_green;
		logic [7:0]  stop_blue;
		logic [7:0]  stop_alpha;
		logic        alpha_present;
	} in_beat_t;

	typedef struct packed {
		logic       status;
		logic       has_color;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} out_beat_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture input beat
		logic scan;      // compare one entry
		logic shift;     // move one entry up
		logic put;       // write new entry at ins
		logic repl;      // overwrite colour at hit
		logic clr;       // empty table
		logic div_start; // start divider
		logic div_sel;   // 0: normalize, 1: ratio
		logic fetch;     // read pair around idx
		logic blend;     // one channel mac
		logic fin;       // finalize result
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic scan_last;
		logic hit;
		logic full;
		logic shift_done;
		logic div_busy;
		logic empty;
		logic need_div;   // normalize needs division
		logic edge_hit;   // empty table or clamp to an outer stop
		logic found;      // search stopped
		logic blend_last;
	} sts_t;

endpackage
`default_nettype wire

### rtl/core/colormap_stop_interpolator.sv
// ----------------------------------------------------------------------------
// colormap_stop_interpolator
// Sorted colour-stop table with piecewise-linear lookup.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one item: append, clear or lookup.
// Output channel out_valid/out_ready carries exactly one result beat per item.
// Configuration: cfg_we with cfg_index 0 (range_min) or 1 (range_max).
// One item at a time. Append scans the table (one entry a cycle), shifts
// entries up one a cycle, then writes. Lookup runs the restoring divider
// for the normalized position when the sample lies strictly inside the
// range, scans the stops one per cycle, runs the divider again for the
// ratio and blends one channel per cycle.
// Reset empties the table and loads range_min 0, range_max 65535.
// A stalled receiver holds the result beat; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module colormap_stop_interpolator #(
	parameter int MAX_STOPS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire cmap_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cmap_pkg::out_beat_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	cmap_pkg::cmd_t cmd;
	cmap_pkg::sts_t sts;

	cmap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_kind(in_data.kind), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	cmap_datapath #(.MAX_STOPS(MAX_STOPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_hit(1'b1), .cfg_data(cfg_data), .in_beat(in_data),
		.cmd(cmd), .sts(sts), .res(out_data)
	);
endmodule
`default_nettype wire

### rtl/core/cmap_div.sv
// ----------------------------------------------------------------------------
// cmap_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
// ----------------------------------------------------------------------------
`default_nettype none
module cmap_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [16:0] num,
	input  wire logic [16:0] den,
	output logic             busy,
	output logic [32:0]      quot
);
	logic [5:0]  cnt_q;
	logic [49:0] rem_q;
	logic [16:0] den_q;
	logic [32:0] quot_q;
	logic [17:0] part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd33;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	assign part = {rem_q[49:33], rem_q[32]};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {17'd0, num, 16'd0};
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != 6'd0) begin
			if (part >= {1'b0, den_q}) begin
				rem_q  <= {(part[16:0] - den_q), rem_q[31:0], 1'b0};
				quot_q <= {quot_q[31:0], 1'b1};
			end else begin
				rem_q  <= {part[16:0], rem_q[31:0], 1'b0};
				quot_q <= {quot_q[31:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign quot = quot_q;
endmodule
`default_nettype wire

### rtl/core/cmap_datapath.sv
// ----------------------------------------------------------------------------
// cmap_datapath
// Stop table, range registers, divider and channel blend.
// ----------------------------------------------------------------------------
`default_nettype none
module cmap_datapath #(
	parameter int MAX_STOPS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_idx,
	input  wire logic                cfg_hit,
	input  wire logic [15:0]         cfg_data,
	input  wire cmap_pkg::in_beat_t  in_beat,
	input  wire cmap_pkg::cmd_t      cmd,
	output cmap_pkg::sts_t           sts,
	output cmap_pkg::out_beat_t      res
);
	localparam int IW = $clog2(MAX_STOPS);
	localparam int CW = $clog2(MAX_STOPS + 1);

	logic [16:0] place_q [MAX_STOPS];
	logic [31:0] rgba_q  [MAX_STOPS];
	logic [CW-1:0] count_q;
	logic [15:0] rmin_q, rmax_q;
	logic [1:0]  kind_q;
	logic [15:0] samp_q;
	logic [16:0] pos_q, t_q;
	logic [31:0] new_rgba_q;
	logic [CW-1:0] idx_q, ins_q, hit_idx_q;
	logic        hit_q, ins_set_q, put_q;
	logic [16:0] p0_q, p1_q;
	logic [31:0] c0_q, c1_q, col_q;
	logic [16:0] r_q;
	logic [1:0]  ch_q;
	logic        status_q;
	logic [16:0] div_num, div_den;
	logic        div_busy;
	logic [32:0] quot;
	logic [IW-1:0] ridx, ridx_m1, widx;

	cmap_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quot(quot)
	);

	assign div_num = cmd.div_sel ? (t_q - p0_q) : {1'b0, samp_q - rmin_q};
	assign div_den = cmd.div_sel ? (p1_q - p0_q) : {1'b0, rmax_q - rmin_q};

	assign ridx    = idx_q[IW-1:0];
	assign ridx_m1 = ridx - IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q  <= 16'd0;
			rmax_q  <= 16'hFFFF;
			count_q <= '0;
		end else begin
			if (cfg_we && cfg_hit && cfg_idx == cmap_pkg::CFG_RANGE_MIN) rmin_q <= cfg_data;
			if (cfg_we && cfg_hit && cfg_idx == cmap_pkg::CFG_RANGE_MAX) rmax_q <= cfg_data;
			if (cmd.clr) count_q <= '0;
			else if (cmd.put) count_q <= count_q + CW'(1);
		end
	end

	assign widx = idx_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			place_q[widx] <= place_q[widx - IW'(1)];
			rgba_q[widx]  <= rgba_q[widx - IW'(1)];
		end else if (cmd.put) begin
			place_q[ins_q[IW-1:0]] <= pos_q;
			rgba_q[ins_q[IW-1:0]]  <= new_rgba_q;
		end else if (cmd.repl) begin
			rgba_q[hit_idx_q[IW-1:0]] <= new_rgba_q;
		end
	end

	function automatic logic [16:0] ONE_sub(input logic [16:0] r);
		return cmap_pkg::ONE_Q16 - r;
	endfunction

	logic [25:0] mac;
	logic [7:0]  a0, a1;
	assign a0  = c0_q[8*ch_q +: 8];
	assign a1  = c1_q[8*ch_q +: 8];
	assign mac = 26'(a0) * 26'(ONE_sub(r_q)) + 26'(a1) * 26'(r_q) + 26'd32768;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= in_beat.kind;
			samp_q     <= in_beat.sample_value;
			pos_q      <= (in_beat.stop_position > cmap_pkg::ONE_Q16) ?
			              cmap_pkg::ONE_Q16 : in_beat.stop_position;
			new_rgba_q <= {in_beat.alpha_present ? in_beat.stop_alpha : 8'hFF,
			               in_beat.stop_blue, in_beat.stop_green, in_beat.stop_red};
			idx_q      <= '0;
			hit_q      <= 1'b0;
			ins_set_q  <= 1'b0;
			put_q      <= 1'b0;
			ins_q      <= count_q;
			hit_idx_q  <= '0;
			status_q   <= 1'b0;
			col_q      <= '0;
			ch_q       <= '0;
			if (in_beat.sample_value <= rmin_q) t_q <= 17'd0;
			else t_q <= cmap_pkg::ONE_Q16;
		end
		if (cmd.put) put_q <= 1'b1;
		if (cmd.scan) begin
			if (kind_q == cmap_pkg::KIND_APPEND) begin
				if (place_q[ridx] == pos_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx_q;
				end
				if (!ins_set_q && !(place_q[ridx] < pos_q)) begin
					ins_set_q <= 1'b1;
					ins_q <= idx_q;
				end
				idx_q <= idx_q + CW'(1);
			end else begin
				// lookup search: stop at first place above t, or at the last stop
				if (!(t_q < place_q[ridx]) && idx_q != count_q - CW'(1))
					idx_q <= idx_q + CW'(1);
			end
		end
		if (cmd.shift) idx_q <= idx_q - CW'(1);
		if (cmd.div_start && !cmd.div_sel) idx_q <= '0;
		if (!cmd.div_start && !div_busy && cmd.fetch == 1'b0 && cmd.div_sel && !cmd.blend
		    && !cmd.scan && !cmd.fin) begin
			if (quot > 33'h10000) r_q <= cmap_pkg::ONE_Q16;
			else r_q <= quot[16:0];
		end
		if (!cmd.div_sel && !div_busy && !cmd.div_start && !cmd.scan && !cmd.load
		    && !cmd.fetch && !cmd.blend && !cmd.fin && sts.need_div)
			t_q <= quot[16:0];
		if (cmd.fetch) begin
			p0_q <= place_q[ridx_m1];
			p1_q <= place_q[ridx];
			c0_q <= rgba_q[ridx_m1];
			c1_q <= rgba_q[ridx];
		end
		if (cmd.blend) begin
			col_q[8*ch_q +: 8] <= mac[23:16];
			ch_q <= ch_q + 2'd1;
		end
		if (cmd.fin) begin
			if (kind_q == cmap_pkg::KIND_APPEND)
				status_q <= !hit_q && !put_q;
			else if (kind_q == cmap_pkg::KIND_LOOKUP) begin
				if (count_q == '0) col_q <= 32'hFFFF_FFFF;
				else if (t_q <= place_q[0]) col_q <= rgba_q[0];
				else if (t_q >= place_q[IW'(count_q - CW'(1))])
					col_q <= rgba_q[IW'(count_q - CW'(1))];
				else if (p1_q <= p0_q) col_q <= c0_q;
			end
		end
	end

	logic lk;
	assign lk = (kind_q == cmap_pkg::KIND_LOOKUP);
	assign sts.scan_last  = (idx_q == count_q - CW'(1));
	assign sts.hit        = hit_q;
	assign sts.full       = (count_q == CW'(MAX_STOPS));
	assign sts.shift_done = (idx_q == ins_q);
	assign sts.div_busy   = div_busy;
	assign sts.empty      = (count_q == '0);
	assign sts.need_div   = (samp_q > rmin_q) && (rmax_q > rmin_q) && (samp_q < rmax_q);
	assign sts.edge_hit   = (count_q == '0) || (t_q <= place_q[0]) ||
	                        (t_q >= place_q[IW'(count_q - CW'(1))]);
	assign sts.found      = (t_q < place_q[ridx]) || (idx_q == count_q - CW'(1));
	assign sts.blend_last = (ch_q == 2'd3) && lk;

	assign res.status    = status_q;
	assign res.has_color = lk;
	assign res.out_red   = col_q[7:0];
	assign res.out_green = col_q[15:8];
	assign res.out_blue  = col_q[23:16];
	assign res.out_alpha = col_q[31:24];
endmodule
`default_nettype wire

### rtl/core/cmap_ctrl.sv
// ----------------------------------------------------------------------------
// cmap_ctrl
// Sequencer for append, clear and lookup items.
// ----------------------------------------------------------------------------
`default_nettype none
module cmap_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     in_kind,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire cmap_pkg::sts_t sts,
	output cmap_pkg::cmd_t      cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_SHIFT = 4'd2;
	localparam logic [3:0] S_PUT   = 4'd3;
	localparam logic [3:0] S_NDIV  = 4'd4;
	localparam logic [3:0] S_NWAIT = 4'd5;
	localparam logic [3:0] S_NTAKE = 4'd6;
	localparam logic [3:0] S_SRCH  = 4'd7;
	localparam logic [3:0] S_FETCH = 4'd8;
	localparam logic [3:0] S_RWAIT = 4'd9;
	localparam logic [3:0] S_RTAKE = 4'd10;
	localparam logic [3:0] S_BLEND = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;
	localparam logic [3:0] S_RDIV  = 4'd14;

	logic [3:0] state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_kind)
						cmap_pkg::KIND_APPEND: state_d = S_SCAN;
						cmap_pkg::KIND_CLEAR: begin
							cmd.clr = 1'b1;
							state_d = S_FIN;
						end
						cmap_pkg::KIND_LOOKUP: state_d = S_NDIV;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				if (sts.empty) begin
					state_d = S_PUT;
				end else begin
					cmd.scan = 1'b1;
					if (sts.scan_last) state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.hit) begin
					cmd.repl = 1'b1;
					state_d = S_FIN;
				end else if (sts.full) begin
					state_d = S_FIN;
				end else if (sts.shift_done) begin
					state_d = S_PUT;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_FIN;
			end
			S_NDIV: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_NWAIT;
				end else begin
					state_d = S_SRCH;
				end
			end
			S_NWAIT: if (!sts.div_busy) state_d = S_NTAKE;
			S_NTAKE: state_d = S_SRCH;
			S_SRCH: begin
				if (sts.empty || sts.edge_hit) begin
					state_d = S_FIN;
				end else if (sts.found) begin
					state_d = S_FETCH;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = S_RDIV;
			end
			S_RDIV: begin
				cmd.div_sel = 1'b1;
				cmd.div_start = 1'b1;
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				cmd.div_sel = 1'b1;
				cmd.fetch = 1'b1;
				if (!sts.div_busy) state_d = S_RTAKE;
			end
			S_RTAKE: begin
				cmd.div_sel = 1'b1;
				state_d = S_BLEND;
			end
			S_BLEND: begin
				cmd.blend = 1'b1;
				if (sts.blend_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/core/cmap_checker.sv
// ----------------------------------------------------------------------------
// cmap_checker
// Port-level checks for the colormap stop interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cmap_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire cmap_pkg::out_beat_t out_data
);
	`ASSERT_IMPL(a_one_side, clk, arst_n, out_valid, !in_ready, "input taken while result pending")
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`ASSERT_IMPL(a_stat_col, clk, arst_n, out_valid && out_data.status, !out_data.has_color, "status on lookup")
	`ASSERT_NEXT(a_no_out_after_in, clk, arst_n, in_valid && in_ready, !out_valid, "result with no work")
endmodule
bind colormap_stop_interpolator cmap_checker u_cmap_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

### verif/tb_colormap_stop_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_colormap_stop_interpolator
// Self-checking bench for the colour-stop table and its interpolated lookup.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, the outer stops, saturated
// positions, replacement, a full table, clear and the unused kind. Random
// phases follow under several range settings, including the degenerate ones.
// Every result beat is checked against its typed row or the colour predictor.
// Both sides idle in random bursts, and the receiver stalls once at length.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_colormap_stop_interpolator;

	localparam int TBL_DEPTH = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam cmap_pkg::out_beat_t BEAT_OK    = '0;
	localparam cmap_pkg::out_beat_t BEAT_FULL  = '{status: 1'b1, default: '0};
	localparam cmap_pkg::out_beat_t BEAT_WHITE = '{1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF};

	typedef struct {
		cmap_pkg::in_beat_t  beat;
		logic                typed;
		cmap_pkg::out_beat_t want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	cmap_pkg::in_beat_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	cmap_pkg::out_beat_t out_data;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_index = cmap_pkg::CFG_RANGE_MIN;
	logic [15:0]         cfg_data = '0;

	// predictor state
	logic [16:0] stop_pos_m[TBL_DEPTH];
	logic [31:0] stop_col_m[TBL_DEPTH];
	int          stop_n_m = 0;
	logic [15:0] rng_lo = 16'd0;
	logic [15:0] rng_hi = 16'd65535;

	cmap_pkg::out_beat_t pending_colors[$];
	stim_row_t           stim_rows[$];
	int          err_cnt = 0;
	int          cycle_cnt = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          full_hits = 0;
	bit          quiet = 1'b0;
	bit          press = 1'b0;

	colormap_stop_interpolator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [16:0] norm_sample(logic [15:0] s);
		if (s <= rng_lo)
			return 17'd0;
		if (rng_hi <= rng_lo || s >= rng_hi)
			return cmap_pkg::ONE_Q16;
		return 17'(((64'(s) - 64'(rng_lo)) << 16) / (64'(rng_hi) - 64'(rng_lo)));
	endfunction

	function automatic logic [31:0] lookup_color(logic [15:0] s);
		logic [16:0] t, p0, p1;
		logic [31:0] c0, c1, res;
		logic [63:0] r, v;
		int i;
		if (stop_n_m == 0)
			return 32'hFFFF_FFFF;
		t = norm_sample(s);
		if (t <= stop_pos_m[0])
			return stop_col_m[0];
		if (t >= stop_pos_m[stop_n_m-1])
			return stop_col_m[stop_n_m-1];
		i = 1;
		while (i < stop_n_m - 1 && t >= stop_pos_m[i])
			i++;
		p0 = stop_pos_m[i-1];
		p1 = stop_pos_m[i];
		c0 = stop_col_m[i-1];
		c1 = stop_col_m[i];
		if (p1 <= p0)
			return c0;
		r = (64'(t - p0) << 16) / 64'(p1 - p0);
		if (r > 64'd65536)
			r = 64'd65536;
		res = '0;
		for (int k = 0; k < 4; k++) begin
			v = 64'(c0[8*k +: 8]) * (64'd65536 - r) + 64'(c1[8*k +: 8]) * r + 64'd32768;
			res[8*k +: 8] = v[23:16];
		end
		return res;
	endfunction

	function automatic logic insert_stop(logic [16:0] pos_in, logic [31:0] rgba);
		logic [16:0] pos;
		int i;
		pos = (pos_in > cmap_pkg::ONE_Q16) ? cmap_pkg::ONE_Q16 : pos_in;
		for (i = 0; i < stop_n_m; i++) begin
			if (stop_pos_m[i] == pos) begin
				stop_col_m[i] = rgba;
				return 1'b0;
			end
		end
		if (stop_n_m >= TBL_DEPTH)
			return 1'b1;
		i = 0;
		while (i < stop_n_m && stop_pos_m[i] < pos)
			i++;
		for (int j = stop_n_m; j > i; j--) begin
			stop_pos_m[j] = stop_pos_m[j-1];
			stop_col_m[j] = stop_col_m[j-1];
		end
		stop_pos_m[i] = pos;
		stop_col_m[i] = rgba;
		stop_n_m++;
		return 1'b0;
	endfunction

	function automatic cmap_pkg::out_beat_t predict_color(cmap_pkg::in_beat_t b);
		cmap_pkg::out_beat_t o;
		logic [31:0] col;
		logic [7:0] a;
		o = '0;
		case (b.kind)
			cmap_pkg::KIND_APPEND: begin
				a = b.alpha_present ? b.stop_alpha : 8'hFF;
				o.status = insert_stop(b.stop_position,
					{a, b.stop_blue, b.stop_green, b.stop_red});
			end
			cmap_pkg::KIND_CLEAR: stop_n_m = 0;
			cmap_pkg::KIND_LOOKUP: begin
				col = lookup_color(b.sample_value);
				o.has_color = 1'b1;
				{o.out_alpha, o.out_blue, o.out_green, o.out_red} = col;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic cmap_pkg::in_beat_t mk_beat(logic [1:0] kind, logic [15:0] s,
			logic [16:0] pos, logic [31:0] rgba, logic ap);
		cmap_pkg::in_beat_t b;
		b.kind = kind;
		b.sample_value = s;
		b.stop_position = pos;
		{b.stop_alpha, b.stop_blue, b.stop_green, b.stop_red} = rgba;
		b.alpha_present = ap;
		return b;
	endfunction

	function automatic void add_row(cmap_pkg::in_beat_t b, logic typed,
			cmap_pkg::out_beat_t want);
		stim_row_t row;
		row.beat = b;
		row.typed = typed;
		row.want = want;
		stim_rows = {stim_rows, row};
	endfunction

	function automatic cmap_pkg::in_beat_t rand_beat();
		cmap_pkg::in_beat_t b;
		int pick;
		b = '0;
		b.stop_red = 8'($urandom);
		b.stop_green = 8'($urandom);
		b.stop_blue = 8'($urandom);
		b.stop_alpha = 8'($urandom);
		b.alpha_present = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (stop_n_m < 3 && pick < 60)
			pick = 70;
		if (pick < 55)
			b.kind = cmap_pkg::KIND_LOOKUP;
		else if (pick < 93)
			b.kind = cmap_pkg::KIND_APPEND;
		else if (pick < 97)
			b.kind = cmap_pkg::KIND_CLEAR;
		else
			b.kind = KIND_UNUSED;
		case ($urandom_range(0, 9))
			0: b.stop_position = 17'($urandom_range(65537, 131071));
			1, 2: b.stop_position = 17'($urandom_range(0, 7) * 8192);
			default: b.stop_position = 17'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 9))
			0: b.sample_value = rng_lo;
			1: b.sample_value = rng_hi;
			2: b.sample_value = 16'($urandom_range(0, 1) ? 0 : 65535);
			default: b.sample_value = 16'($urandom);
		endcase
		return b;
	endfunction

	task automatic send_beat(cmap_pkg::in_beat_t b, logic typed, cmap_pkg::out_beat_t want);
		cmap_pkg::out_beat_t pred;
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		pred = predict_color(b);
		pending_colors = {pending_colors, (typed ? want : pred)};
		beats_in++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic drain_and_write(logic [0:0] idx, logic [15:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == cmap_pkg::CFG_RANGE_MIN)
			rng_lo = val;
		else
			rng_hi = val;
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (press) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				press = 1'b0;
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!quiet && $urandom_range(0, 1)) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending_colors.size() == 0) begin
				$error("result beat with nothing expected");
				err_cnt++;
			end else begin : cmp
				cmap_pkg::out_beat_t w;
				w = pending_colors.pop_front();
				if (w.status) full_hits++;
				if (out_data.status !== w.status) begin
					$error("status exp %0d got %0d", w.status, out_data.status);
					err_cnt++;
				end
				if (out_data.has_color !== w.has_color) begin
					$error("has_color exp %0d got %0d", w.has_color, out_data.has_color);
					err_cnt++;
				end
				if (out_data.out_red !== w.out_red) begin
					$error("out_red exp %0d got %0d", w.out_red, out_data.out_red);
					err_cnt++;
				end
				if (out_data.out_green !== w.out_green) begin
					$error("out_green exp %0d got %0d", w.out_green, out_data.out_green);
					err_cnt++;
				end
				if (out_data.out_blue !== w.out_blue) begin
					$error("out_blue exp %0d got %0d", w.out_blue, out_data.out_blue);
					err_cnt++;
				end
				if (out_data.out_alpha !== w.out_alpha) begin
					$error("out_alpha exp %0d got %0d", w.out_alpha, out_data.out_alpha);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] lo_set[6];
		logic [15:0] hi_set[6];
		lo_set = '{16'd0, 16'd0, 16'd65535, 16'd40000, 16'd1000, 16'd65535};
		hi_set = '{16'd0, 16'd65535, 16'd65535, 16'd20000, 16'd1200, 16'd0};

		// directed rows
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'd0, '0, '0, 1'b0), 1'b1, BEAT_WHITE);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'hFFFF, '0, '0, 1'b1), 1'b1, BEAT_WHITE);
		add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, 17'd0, 32'h0000_00FF, 1'b0),
			1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, cmap_pkg::ONE_Q16, 32'h00FF_0000, 1'b1),
			1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'd0, '0, '0, 1'b0), 1'b1,
			'{1'b0, 1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF});
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'hFFFF, '0, '0, 1'b0), 1'b1,
			'{1'b0, 1'b1, 8'h00, 8'h00, 8'hFF, 8'h00});
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'h8000, '0, '0, 1'b0), 1'b0, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1),
			1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, 17'h08000, 32'h1234_5678, 1'b1),
			1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'h4000, '0, '0, 1'b0), 1'b0, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'hC000, '0, '0, 1'b0), 1'b0, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'hFFFE, '0, '0, 1'b0), 1'b0, BEAT_OK);
		add_row(mk_beat(KIND_UNUSED, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1), 1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_CLEAR, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1),
			1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'h1234, '0, '0, 1'b0), 1'b1, BEAT_WHITE);
		for (int i = 0; i < TBL_DEPTH; i++)
			add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, 17'(i * 4000 + 500), {$urandom},
				1'(i)), 1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, 17'd1, 32'h0, 1'b1), 1'b1, BEAT_FULL);
		add_row(mk_beat(cmap_pkg::KIND_APPEND, 16'd0, 17'd4500, 32'hA5A5_A5A5, 1'b1),
			1'b1, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'd300, '0, '0, 1'b0), 1'b0, BEAT_OK);
		add_row(mk_beat(cmap_pkg::KIND_LOOKUP, 16'd30000, '0, '0, 1'b0), 1'b0, BEAT_OK);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);

		// long receiver hold while the sender keeps offering
		press = 1'b1;
		repeat (60) send_beat(rand_beat(), 1'b0, BEAT_OK);

		for (int ph = 0; ph < 6; ph++) begin
			drain_and_write(cmap_pkg::CFG_RANGE_MIN, lo_set[ph]);
			drain_and_write(cmap_pkg::CFG_RANGE_MAX, hi_set[ph]);
			repeat (55) send_beat(rand_beat(), 1'b0, BEAT_OK);
		end
		drain_and_write(cmap_pkg::CFG_RANGE_MIN, 16'($urandom));
		drain_and_write(cmap_pkg::CFG_RANGE_MAX, 16'($urandom));
		repeat (60) send_beat(rand_beat(), 1'b0, BEAT_OK);
		drain_and_write(cmap_pkg::CFG_RANGE_MIN, 16'd0);
		drain_and_write(cmap_pkg::CFG_RANGE_MAX, 16'd65535);
		repeat (60) send_beat(rand_beat(), 1'b0, BEAT_OK);

		quiet = 1'b1;
		repeat (40) send_beat(rand_beat(), 1'b0, BEAT_OK);
		in_valid <= 1'b0;

		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d items, checked %0d results, %0d full-table rejects seen.",
			beats_in, beats_out, full_hits);
		$display("Range settings covered reset, degenerate, inverted, narrow and random.");
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
